/* design/wvm_pkg.sv */
// Shared types and constants of the wavetable voice mixer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package wvm_pkg;

   localparam int TABLE_SHIFT     = 7;   // phase to table index shift, 0..14
   localparam int VOICES          = 8;   // active voices, 1..8
   localparam int NUM_VOICE_SLOTS = 8;   // step fields carried by every tick
   localparam int VIDX_W          = 3;
   localparam int PHASE_W         = 15;
   localparam logic [PHASE_W-1:0] PHASE_MOD = 15'h7FFF;
   localparam int TABLE_AW        = 8;
   localparam int TABLE_DEPTH     = 256;
   localparam int WORD_W          = 8;
   localparam int COUNT_W         = 4;
   localparam int SAMPLE_W        = 11;
   localparam int DIV_STEPS       = SAMPLE_W;  // one quotient bit per step
   localparam int CNT_W           = 4;

   typedef enum logic {
      OP_TICK        = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_VOICE = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic              tick_load;
      logic              tbl_wr;
      logic              voice_en;
      logic [VIDX_W-1:0] voice_idx;
      logic              div_step;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic out_free;
   } status_type;

endpackage

/* design/wvm_ctrl.sv */
// Sequencer of the wavetable voice mixer: voice walk, divide steps, result hand-off.
// Depends on wvm_pkg.
`timescale 1ns / 1ps

module wvm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   input  wvm_pkg::status_type status,
   output logic                req_stall,
   output wvm_pkg::cmd_type    cmd
);
   import wvm_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_TABLE_WRITE) begin
                  cmd.tbl_wr = 1'b1;
               end else begin
                  cmd.tick_load = 1'b1;
                  cnt_in        = '0;
                  state_in      = ST_VOICE;
               end
            end
         end
         ST_VOICE: begin
            cmd.voice_en  = 1'b1;
            cmd.voice_idx = cnt_ff[VIDX_W-1:0];
            if (cnt_ff == CNT_W'(NUM_VOICE_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last table read lands in the accumulator here
            cnt_in   = '0;
            state_in = status.count_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* design/wvm_datapath.sv */
// Datapath of the wavetable voice mixer: phase accumulators, waveform table,
// mix accumulator, restoring divider and output register. Depends on wvm_pkg.
`timescale 1ns / 1ps

module wvm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  wvm_pkg::cmd_type                cmd,
   output wvm_pkg::status_type             status,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_0,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_1,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_2,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_3,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_4,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_5,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_6,
   input  logic [wvm_pkg::PHASE_W-1:0]     req_voice_step_7,
   input  logic [wvm_pkg::COUNT_W-1:0]     req_voice_count,
   input  logic [wvm_pkg::TABLE_AW-1:0]    req_table_address,
   input  logic [wvm_pkg::WORD_W-1:0]      req_table_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wvm_pkg::SAMPLE_W-1:0]    rsp_sample,
   output logic                            rsp_divide_by_zero
);
   import wvm_pkg::*;

   logic [PHASE_W-1:0]  step_ff  [NUM_VOICE_SLOTS];
   logic [PHASE_W-1:0]  phase_ff [NUM_VOICE_SLOTS];
   logic [WORD_W-1:0]   table_mem [TABLE_DEPTH];
   logic [COUNT_W-1:0]  count_ff;
   logic [WORD_W-1:0]   rd_data_ff;
   logic                pend_ff, pend_in;
   logic [SAMPLE_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                dbz_ff;

   logic [PHASE_W-1:0]  cur_step, cur_phase, adv_phase, phase_next;
   logic [PHASE_W:0]    phase_sum;
   logic                slot_used, voice_active;
   logic [PHASE_W-1:0]  phase_shr;
   logic [TABLE_AW-1:0] tbl_idx;
   logic [COUNT_W:0]    rem_sh;
   logic                q_bit;
   logic                count_zero;

   // phase advance of the voice being walked, modulo 0x7FFF
   always_comb begin
      cur_step  = step_ff[cmd.voice_idx];
      cur_phase = phase_ff[cmd.voice_idx];
      phase_sum = {1'b0, cur_phase} + {1'b0, cur_step};
      if (cur_step == '0) begin
         adv_phase = '0;
      end else if (phase_sum < {1'b0, PHASE_MOD}) begin
         adv_phase = phase_sum[PHASE_W-1:0];
      end else begin
         adv_phase = PHASE_W'(phase_sum - {1'b0, PHASE_MOD});
      end
      slot_used    = ({1'b0, cmd.voice_idx} < (VIDX_W+1)'(VOICES));
      phase_next   = slot_used ? adv_phase : '0;
      voice_active = slot_used && (cur_step != '0);
      phase_shr    = phase_next >> TABLE_SHIFT;
      tbl_idx      = phase_shr[TABLE_AW-1:0];
   end

   // restoring divide, one quotient bit per step, quotient shifts into acc
   assign count_zero = (count_ff == '0);
   assign rem_sh     = {rem_ff, acc_ff[SAMPLE_W-1]};
   assign q_bit      = (rem_sh >= {1'b0, count_ff});

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      pend_in = cmd.voice_en && voice_active;
      if (cmd.tick_load) begin
         acc_in = '0;
         rem_in = '0;
      end else if (cmd.div_step) begin
         acc_in = {acc_ff[SAMPLE_W-2:0], q_bit};
         rem_in = q_bit ? COUNT_W'(rem_sh - {1'b0, count_ff}) : rem_sh[COUNT_W-1:0];
      end else if (pend_ff) begin
         acc_in = acc_ff + SAMPLE_W'(rd_data_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) begin
         table_mem[req_table_address] <= req_table_word;
      end
      rd_data_ff <= table_mem[tbl_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_load) begin
         step_ff[0] <= req_voice_step_0;
         step_ff[1] <= req_voice_step_1;
         step_ff[2] <= req_voice_step_2;
         step_ff[3] <= req_voice_step_3;
         step_ff[4] <= req_voice_step_4;
         step_ff[5] <= req_voice_step_5;
         step_ff[6] <= req_voice_step_6;
         step_ff[7] <= req_voice_step_7;
         count_ff   <= req_voice_count;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (cmd.out_load) begin
         sample_ff <= count_zero ? '0 : acc_ff;
         dbz_ff    <= count_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICE_SLOTS; i++) begin
            phase_ff[i] <= '0;
         end
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.voice_en) begin
            phase_ff[cmd.voice_idx] <= phase_next;
         end
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.count_zero  = count_zero;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = sample_ff;
   assign rsp_divide_by_zero = dbz_ff;

endmodule

/* design/wavetable_voice_mixer_unit.sv */
// Top level of the eight-voice wavetable mixer: sequencer plus datapath.
// Depends on wvm_pkg, wvm_ctrl and wvm_datapath.
`timescale 1ns / 1ps

// Eight-voice wavetable oscillator mixer. A table-write item (op = 1) stores
// one 8-bit word of the shared 256-entry waveform table in the cycle it is
// accepted and returns no result; the block is ready again the next cycle.
// A sample-tick item (op = 0) advances each voice's 15-bit phase by its step
// modulo 0x7FFF (a zero step clears the phase and silences the voice), reads
// the table at phase >> 7, sums the reads and divides by voice_count. A
// count of zero returns sample 0 with divide_by_zero set. After a tick is
// accepted the input stays stalled while the voices are walked through the
// table's single read port, the last read is drained, the bit-serial divide
// runs (skipped on a zero count) and the output register is loaded, which
// waits while a previous result is still held by rsp_stall. The finished
// item sits in that register, so the next item can be accepted while
// rsp_stall holds the previous one. Table entries must be written before a
// tick reads them.

module wavetable_voice_mixer_unit (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_0,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_1,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_2,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_3,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_4,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_5,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_6,
   input  logic [wvm_pkg::PHASE_W-1:0]  req_voice_step_7,
   input  logic [wvm_pkg::COUNT_W-1:0]  req_voice_count,
   input  logic [wvm_pkg::TABLE_AW-1:0] req_table_address,
   input  logic [wvm_pkg::WORD_W-1:0]   req_table_word,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [wvm_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                         rsp_divide_by_zero
);
   import wvm_pkg::*;

   cmd_type    cmd;     // sequencer -> datapath
   status_type status;  // datapath -> sequencer

   // the sequencer raises tick_load and tbl_wr only while it sees req_valid in idle,
   // so an accepted item is exactly req_valid with req_stall low
   wvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   wvm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_voice_step_0   (req_voice_step_0),
      .req_voice_step_1   (req_voice_step_1),
      .req_voice_step_2   (req_voice_step_2),
      .req_voice_step_3   (req_voice_step_3),
      .req_voice_step_4   (req_voice_step_4),
      .req_voice_step_5   (req_voice_step_5),
      .req_voice_step_6   (req_voice_step_6),
      .req_voice_step_7   (req_voice_step_7),
      .req_voice_count    (req_voice_count),
      .req_table_address  (req_table_address),
      .req_table_word     (req_table_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

/* design/wvm_checker.sv */
// Port-level checks of the wavetable voice mixer, bound to the top level.
// Depends on wvm_pkg and wavetable_voice_mixer_unit.
`timescale 1ns / 1ps

module wvm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_op,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [wvm_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                         rsp_divide_by_zero
);
   import wvm_pkg::*;

   // a held result does not move
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample)
                                 && $stable(rsp_divide_by_zero))
      else $error("result changed while stalled");

   // zero divisor forces a zero sample
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_sample == '0)
      else $error("divide_by_zero with nonzero sample");

   // eight 8-bit reads over a divisor of at least one stay within 2040
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample <= SAMPLE_W'(2040))
      else $error("sample out of range");

   // no item produces a result in the cycle right after its acceptance
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a tick keeps the input busy while the voices are walked
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_TICK) |=> req_stall)
      else $error("input ready right after a tick");

endmodule

bind wavetable_voice_mixer_unit wvm_checker u_wvm_checker (.*);

/* bench/tb_wavetable_voice_mixer_unit.sv */
// Self-checking bench for the eight-voice wavetable mixer: directed rows, then random items.
// Depends on wvm_pkg and the wavetable_voice_mixer_unit RTL only.
`timescale 1ns / 1ps

module tb_wavetable_voice_mixer_unit;
   import wvm_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 400000;  // many times the slowest legal run
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 40;      // idle margin after the last result
   localparam int REPORT_MAX   = 10;

   // One item as driven, plus an optional hand-written result for directed rows.
   typedef struct packed {
      op_type                                   op;
      logic [NUM_VOICE_SLOTS-1:0][PHASE_W-1:0]  step;
      logic [COUNT_W-1:0]                       count;
      logic [TABLE_AW-1:0]                      addr;
      logic [WORD_W-1:0]                        word;
      logic                                     known;
      logic [SAMPLE_W-1:0]                      known_sample;
      logic                                     known_dz;
   } mix_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                dz;
   } mix_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_sample;
   logic                 rsp_divide_by_zero;
   mix_item_type         cur_item = '0;

   // Idle rates in percent per cycle, changed by the stimulus between phases.
   int unsigned          req_idle_pct = 32;
   int unsigned          rsp_idle_pct = 69;
   bit                   rsp_hold_req = 1'b0;

   // Predictor state: voice phases and the waveform table as seen by accepted items.
   logic [PHASE_W-1:0]   voice_phase [NUM_VOICE_SLOTS];
   logic [WORD_W-1:0]    wave_mem [TABLE_DEPTH];
   bit                   wave_written [TABLE_DEPTH];
   int                   written_entries = 0;
   mix_result_type       expected_samples [$];

   int                   error_count = 0;
   int                   tick_count = 0;
   int                   zero_count_ticks = 0;
   int                   write_count = 0;
   int                   checked_count = 0;

   wavetable_voice_mixer_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (cur_item.op),
      .req_voice_step_0   (cur_item.step[0]),
      .req_voice_step_1   (cur_item.step[1]),
      .req_voice_step_2   (cur_item.step[2]),
      .req_voice_step_3   (cur_item.step[3]),
      .req_voice_step_4   (cur_item.step[4]),
      .req_voice_step_5   (cur_item.step[5]),
      .req_voice_step_6   (cur_item.step[6]),
      .req_voice_step_7   (cur_item.step[7]),
      .req_voice_count    (cur_item.count),
      .req_table_address  (cur_item.addr),
      .req_table_word     (cur_item.word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still pending",
               CYCLE_LIMIT, expected_samples.size());
      $display("[wavetable_voice_mixer_unit] ERROR");
      $finish;
   end

   initial begin
      for (int v = 0; v < NUM_VOICE_SLOTS; v++) voice_phase[v] = '0;
      for (int a = 0; a < TABLE_DEPTH; a++) begin
         wave_mem[a]     = '0;
         wave_written[a] = 1'b0;
      end
   end

   // Phase accumulator step: zero clears, otherwise add modulo 0x7FFF.
   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
                                                     input logic [PHASE_W-1:0] s);
      logic [PHASE_W:0] sum;
      sum = {1'b0, p} + {1'b0, s};
      if (s == '0) return '0;
      if (sum < {1'b0, PHASE_MOD}) return sum[PHASE_W-1:0];
      return PHASE_W'(sum - {1'b0, PHASE_MOD});
   endfunction

   function automatic logic [TABLE_AW-1:0] table_index(input logic [PHASE_W-1:0] p);
      return TABLE_AW'(p >> TABLE_SHIFT);
   endfunction

   // Update the mixer state for one accepted item; a tick queues one result.
   function automatic void predict_mix(input mix_item_type it);
      mix_result_type r;
      int unsigned total;
      if (it.op == OP_TABLE_WRITE) begin
         if (!wave_written[it.addr]) written_entries++;
         wave_mem[it.addr]     = it.word;
         wave_written[it.addr] = 1'b1;
         write_count++;
         return;
      end
      total = 0;
      for (int v = 0; v < NUM_VOICE_SLOTS; v++) begin
         if (v >= VOICES) begin
            voice_phase[v] = '0;
            continue;
         end
         voice_phase[v] = next_phase(voice_phase[v], it.step[v]);
         if (it.step[v] != '0) total += wave_mem[table_index(voice_phase[v])];
      end
      if (it.count == '0) begin
         r.sample = '0;
         r.dz     = 1'b1;
         zero_count_ticks++;
      end else begin
         r.sample = SAMPLE_W'(total / it.count);
         r.dz     = 1'b0;
      end
      // directed rows carry their own hand-computed answer
      if (it.known) begin
         r.sample = it.known_sample;
         r.dz     = it.known_dz;
      end
      tick_count++;
      expected_samples.push_back(r);
   endfunction

   function automatic void note_error(input string msg);
      if (error_count < REPORT_MAX) $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endfunction

   // Inputs are stable here (driven at the falling edge); DUT outputs are pre-edge values.
   always @(posedge clock) begin : monitor
      mix_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_mix(cur_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               note_error($sformatf("unexpected result sample=%0d dz=%0d",
                                    rsp_sample, rsp_divide_by_zero));
            end else begin
               want = expected_samples.pop_front();
               checked_count++;
               if (rsp_sample !== want.sample)
                  note_error($sformatf("sample exp %0d got %0d", want.sample, rsp_sample));
               if (rsp_divide_by_zero !== want.dz)
                  note_error($sformatf("divide_by_zero exp %0d got %0d",
                                       want.dz, rsp_divide_by_zero));
            end
         end
      end
   end

   // Result side: random stall per cycle, or one long hold-off when asked for.
   initial begin : rsp_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   function automatic mix_item_type tick_row(input int s0, input int s1, input int s2,
                                             input int s3, input int s4, input int s5,
                                             input int s6, input int s7, input int cnt);
      mix_item_type it;
      it         = '0;
      it.op      = OP_TICK;
      it.step[0] = PHASE_W'(s0);
      it.step[1] = PHASE_W'(s1);
      it.step[2] = PHASE_W'(s2);
      it.step[3] = PHASE_W'(s3);
      it.step[4] = PHASE_W'(s4);
      it.step[5] = PHASE_W'(s5);
      it.step[6] = PHASE_W'(s6);
      it.step[7] = PHASE_W'(s7);
      it.count   = COUNT_W'(cnt);
      it.addr    = 8'hA5;  // ignored on a tick
      it.word    = 8'h5A;
      return it;
   endfunction

   function automatic mix_item_type known_result(input mix_item_type it, input int smp,
                                                 input bit dz);
      it.known        = 1'b1;
      it.known_sample = SAMPLE_W'(smp);
      it.known_dz     = dz;
      return it;
   endfunction

   // Table write with every ignored field at all ones.
   function automatic mix_item_type write_row(input int a, input int w);
      mix_item_type it;
      it       = '0;
      it.op    = OP_TABLE_WRITE;
      it.step  = '1;
      it.count = '1;
      it.addr  = TABLE_AW'(a);
      it.word  = WORD_W'(w);
      return it;
   endfunction

   function automatic logic [PHASE_W-1:0] random_step();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return '0;
      if (roll < 30) begin
         case ($urandom_range(0, 2))
            0: return PHASE_W'(1);
            1: return PHASE_W'(32766);
            default: return PHASE_W'(32767);
         endcase
      end
      return PHASE_W'($urandom_range(1, 32767));
   endfunction

   // Built against the predictor state of the moment, so no tick reads an unwritten entry.
   function automatic mix_item_type build_random_item();
      mix_item_type it;
      int unsigned write_pct;
      int unsigned roll;
      int a;
      it.op    = OP_TICK;
      for (int v = 0; v < NUM_VOICE_SLOTS; v++) it.step[v] = PHASE_W'($urandom);
      it.count = COUNT_W'($urandom);
      it.addr  = TABLE_AW'($urandom);
      it.word  = WORD_W'($urandom);
      it.known = 1'b0;
      it.known_sample = '0;
      it.known_dz     = 1'b0;
      write_pct = (written_entries < TABLE_DEPTH) ? 60 : 25;
      if ($urandom_range(0, 99) < write_pct) begin
         it.op = OP_TABLE_WRITE;
         if (written_entries < TABLE_DEPTH) begin
            // fill pass: land on an entry not written yet
            a = $urandom_range(0, TABLE_DEPTH - 1);
            while (wave_written[a]) a = (a + 1) % TABLE_DEPTH;
            it.addr = TABLE_AW'(a);
         end
      end else begin
         for (int v = 0; v < NUM_VOICE_SLOTS; v++) begin
            it.step[v] = random_step();
            if (v < VOICES && it.step[v] != '0 &&
                !wave_written[table_index(next_phase(voice_phase[v], it.step[v]))])
               it.step[v] = '0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 10)      it.count = '0;
         else if (roll < 25) it.count = COUNT_W'($urandom_range(9, 15));
         else                it.count = COUNT_W'($urandom_range(1, 8));
      end
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer_item(input bit make_random, input mix_item_type fixed);
      mix_item_type it;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      it = make_random ? build_random_item() : fixed;
      cur_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin : stimulus
      mix_item_type rows[$];

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset: every voice silent, no table reads
      rows.push_back(known_result(tick_row(0, 0, 0, 0, 0, 0, 0, 0, 1), 0, 1'b0));
      rows.push_back(known_result(tick_row(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1'b1));
      rows.push_back(write_row(0, 255));
      rows.push_back(write_row(255, 8'h5A));
      rows.push_back(write_row(1, 0));
      rows.push_back(write_row(85, 8'h55));
      rows.push_back(write_row(170, 8'hAA));
      // single voice on entry 0
      rows.push_back(known_result(tick_row(1, 0, 0, 0, 0, 0, 0, 0, 1), 255, 1'b0));
      // all voices on entry 0: largest sample
      rows.push_back(known_result(tick_row(1, 1, 1, 1, 1, 1, 1, 1, 1), 2040, 1'b0));
      rows.push_back(known_result(tick_row(1, 1, 1, 1, 1, 1, 1, 1, 8), 255, 1'b0));
      // divisor above eight
      rows.push_back(tick_row(1, 1, 1, 1, 1, 1, 1, 1, 15));
      // zero count while voices run: phases still move
      rows.push_back(known_result(tick_row(1, 1, 1, 1, 1, 1, 1, 1, 0), 0, 1'b1));
      // step 32767 holds phase, 32766 steps back, top entry, mid entries, clears
      rows.push_back(tick_row(32767, 32766, 32640, 10880, 21760, 128, 0, 0, 5));
      // write does not touch phases
      rows.push_back(write_row(2, 8'h33));
      // voice 2 lands exactly on the modulus and wraps to zero
      rows.push_back(tick_row(0, 1, 123, 0, 0, 0, 1, 32767, 3));
      rows.push_back(known_result(tick_row(0, 0, 0, 0, 0, 0, 0, 0, 8), 0, 1'b0));

      foreach (rows[i]) offer_item(1'b0, rows[i]);

      // random part: three idle profiles, long result hold-off at the start of the last
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            req_idle_pct = 69;
            rsp_idle_pct = 32;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            rsp_hold_req = 1'b1;
         end
         offer_item(1'b1, '0);
      end
      req_valid <= 1'b0;

      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d sample ticks (%0d with zero count) and %0d table writes,",
               tick_count, zero_count_ticks, write_count);
      $display("%0d of %0d table entries filled, %0d results checked, %0d mismatches",
               written_entries, TABLE_DEPTH, checked_count, error_count);
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("[wavetable_voice_mixer_unit] OK");
      end else begin
         $display("[wavetable_voice_mixer_unit] ERROR");
      end
      $finish;
   end

endmodule
